// ----- rtl/lcpt_pkg.sv -----
// shared types, constants and pattern tables for the led chaser with pwm tail
`default_nettype none

package lcpt_pkg;

	// ring geometry
	localparam int RING_DEPTH = 16;
	localparam int LED_COUNT  = 8;
	localparam int RING_IDX_W = $clog2(RING_DEPTH);

	// field widths
	localparam int DUTY_W  = 8;
	localparam int LEVEL_W = 8;
	localparam int PHASE_W = 2;
	localparam int CFG_W   = 8;
	localparam int CFG_IDX_W = 2;
	localparam int ROT_W   = 4;

	// pattern tables
	localparam int TABLE_LEN = 16;
	localparam logic [DUTY_W-1:0] LEFT_TAB [TABLE_LEN] = '{
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd100, 8'd50, 8'd25, 8'd12, 8'd6, 8'd3, 8'd1, 8'd0
	};
	localparam logic [DUTY_W-1:0] RIGHT_TAB [TABLE_LEN] = '{
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd1, 8'd3, 8'd6, 8'd12, 8'd25, 8'd50, 8'd100
	};

	// displays per phase
	localparam logic [ROT_W:0] SWEEP_ROTATIONS  = 5'd9;
	localparam logic [ROT_W:0] CENTER_ROTATIONS = 5'd15;

	// register reset values
	localparam logic [CFG_W-1:0] FRAMES_RESET = 8'd4;
	localparam logic [CFG_W-1:0] PERIOD_RESET = 8'd100;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_SHIFT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD       = 2'd1;

	typedef enum logic [PHASE_W-1:0] {
		PH_RIGHT  = 2'd0,
		PH_LEFT   = 2'd1,
		PH_CENTER = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_LOAD_RIGHT,
		CMD_LOAD_LEFT,
		CMD_LOAD_CENTER,
		CMD_ROT_RIGHT,
		CMD_ROT_LEFT,
		CMD_CENTER_STEP
	} cell_cmd_t;

	// control broadcast to every ring cell
	typedef struct packed {
		cell_cmd_t          cmd;
		logic [DUTY_W-1:0]  step;
	} cell_ctl_t;

	// per-cell load values, fixed by the cell position
	typedef struct packed {
		logic [DUTY_W-1:0] sweep_right;
		logic [DUTY_W-1:0] sweep_left;
		logic [DUTY_W-1:0] sweep_center;
		logic [DUTY_W-1:0] left_plain;
		logic [DUTY_W-1:0] right_plain;
		logic [DUTY_W-1:0] left_rot;
		logic [DUTY_W-1:0] right_rot;
	} cell_load_t;

	// table entries beyond the given ones read as zero
	function automatic logic [DUTY_W-1:0] left_entry(input int idx);
		logic [DUTY_W-1:0] v;
		v = '0;
		if (idx < TABLE_LEN) begin
			v = LEFT_TAB[idx];
		end
		return v;
	endfunction

	function automatic logic [DUTY_W-1:0] right_entry(input int idx);
		logic [DUTY_W-1:0] v;
		v = '0;
		if (idx < TABLE_LEN) begin
			v = RIGHT_TAB[idx];
		end
		return v;
	endfunction

	function automatic logic [DUTY_W-1:0] duty_max(input logic [DUTY_W-1:0] a,
		input logic [DUTY_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

	// load values for the cell at position idx
	function automatic cell_load_t cell_load(input int idx);
		cell_load_t l;
		int prv;
		int nxt;
		prv = (idx + RING_DEPTH - 1) % RING_DEPTH;
		nxt = (idx + 1) % RING_DEPTH;
		l.sweep_right  = right_entry(prv);
		l.sweep_left   = left_entry(nxt);
		l.left_rot     = left_entry(nxt);
		l.right_rot    = right_entry(prv);
		l.sweep_center = duty_max(left_entry(nxt), right_entry(prv));
		l.left_plain   = left_entry(idx);
		l.right_plain  = right_entry(idx);
		return l;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/lcpt_if.sv -----
// handshake channel interfaces: tick input, led result and configuration write
`default_nettype none

interface lcpt_tick_if import lcpt_pkg::*; ();
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface lcpt_led_if import lcpt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] led_levels;
	logic [PHASE_W-1:0] phase;
	logic               period_start;

	modport source (output valid, output led_levels, output phase, output period_start,
		input ready);
	modport sink (input valid, input led_levels, input phase, input period_start,
		output ready);
endinterface

interface lcpt_cfg_if import lcpt_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/led_chaser_pwm_tail_unit.sv -----
// top level of the led chaser with pwm fading tail: control plus a ring of cells
//
//  channel | role | transfer carries
//  --------+------+---------------------------------------------------
//  tick    | sink | restart
//  led     | src  | led_levels, phase, period_start
//  cfg     | sink | index (0 frames_per_shift, 1 pwm_period), data
//
// one tick per cycle while the result is taken; its result is registered and shows in the cycle after the transfer.
// all ring entries load or rotate in that same cycle through neighbour links of the cells.
// a stalled result holds tick.ready low only while led.ready is low; cfg is always ready.
// reset loads the rings and counters at once, no clearing pass.
`default_nettype none

module led_chaser_pwm_tail_unit import lcpt_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lcpt_tick_if.sink  tick,
	lcpt_led_if.source led,
	lcpt_cfg_if.sink   cfg
);

	cell_ctl_t          ctl;
	logic [DUTY_W-1:0]  sweep [RING_DEPTH];
	logic [DUTY_W-1:0]  left  [RING_DEPTH];
	logic [DUTY_W-1:0]  right [RING_DEPTH];
	logic [RING_DEPTH-1:0] off;
	logic [LEVEL_W-1:0] led_off;

	lcpt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick),
		.led     (led),
		.cfg     (cfg),
		.led_off (led_off),
		.ctl     (ctl)
	);

	// ring of cells, each linked to both neighbours
	for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
		localparam int PRV = (i + RING_DEPTH - 1) % RING_DEPTH;
		localparam int NXT = (i + 1) % RING_DEPTH;
		cell_load_t load;

		assign load = cell_load(i);

		lcpt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.load       (load),
			.sweep_prev (sweep[PRV]),
			.sweep_next (sweep[NXT]),
			.left_next  (left[NXT]),
			.right_prev (right[PRV]),
			.sweep      (sweep[i]),
			.left       (left[i]),
			.right      (right[i]),
			.off        (off[i])
		);
	end

	// led off bits: leds past the ring are off, leds past the count are not shown
	for (genvar j = 0; j < LEVEL_W; j++) begin : g_led
		if (j < LED_COUNT && j < RING_DEPTH) begin : g_ring
			assign led_off[j] = off[j];
		end else if (j < LED_COUNT) begin : g_dark
			assign led_off[j] = 1'b1;
		end else begin : g_none
			assign led_off[j] = 1'b0;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/lcpt_cell.sv -----
// one ring cell: holds one entry of each duty ring and its led compare
`default_nettype none

module lcpt_cell import lcpt_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cell_ctl_t         ctl,
	input  wire cell_load_t        load,
	input  wire logic [DUTY_W-1:0] sweep_prev,
	input  wire logic [DUTY_W-1:0] sweep_next,
	input  wire logic [DUTY_W-1:0] left_next,
	input  wire logic [DUTY_W-1:0] right_prev,
	output logic      [DUTY_W-1:0] sweep,
	output logic      [DUTY_W-1:0] left,
	output logic      [DUTY_W-1:0] right,
	output logic                   off
);

	logic [DUTY_W-1:0] sweep_q;
	logic [DUTY_W-1:0] left_q;
	logic [DUTY_W-1:0] right_q;

	// ring entries: load, rotate or hold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= load.sweep_right;
			left_q  <= load.left_plain;
			right_q <= load.right_plain;
		end else begin
			case (ctl.cmd)
				CMD_LOAD_RIGHT: begin
					sweep_q <= load.sweep_right;
					left_q  <= load.left_plain;
					right_q <= load.right_plain;
				end
				CMD_LOAD_LEFT: begin
					sweep_q <= load.sweep_left;
				end
				CMD_LOAD_CENTER: begin
					sweep_q <= load.sweep_center;
					left_q  <= load.left_rot;
					right_q <= load.right_rot;
				end
				CMD_ROT_RIGHT: begin
					sweep_q <= sweep_prev;
				end
				CMD_ROT_LEFT: begin
					sweep_q <= sweep_next;
				end
				CMD_CENTER_STEP: begin
					left_q  <= left_next;
					right_q <= right_prev;
					sweep_q <= duty_max(left_next, right_prev);
				end
				default: begin
					sweep_q <= sweep_q;
				end
			endcase
		end
	end

	// led off once the step reaches the duty value
	assign off   = (ctl.step >= sweep_q);
	assign sweep = sweep_q;
	assign left  = left_q;
	assign right = right_q;

endmodule

`default_nettype wire

// ----- rtl/lcpt_ctrl.sv -----
// counters, phase sequencing, configuration registers and result register
`default_nettype none

module lcpt_ctrl import lcpt_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	lcpt_tick_if.sink               tick,
	lcpt_led_if.source              led,
	lcpt_cfg_if.sink                cfg,
	input  wire logic [LEVEL_W-1:0] led_off,
	output cell_ctl_t               ctl
);

	logic [CFG_W-1:0]  frames_q;
	logic [CFG_W-1:0]  period_q;
	logic [DUTY_W-1:0] step_q;
	logic [CFG_W-1:0]  frame_q;
	logic [ROT_W-1:0]  rot_q;
	phase_t            phase_q;

	logic               out_valid_q;
	logic [LEVEL_W-1:0] levels_q;
	logic [PHASE_W-1:0] phase_out_q;
	logic               start_q;

	logic              accept;
	phase_t            cur_phase;
	phase_t            next_phase;
	logic [DUTY_W:0]   step_inc;
	logic [CFG_W:0]    frame_inc;
	logic [ROT_W:0]    rot_inc;
	logic [ROT_W:0]    rot_limit;
	logic              step_wrap;
	logic              frame_wrap;
	logic              phase_end;

	// a result waiting in the output register holds off the next tick until led.ready is high
	assign tick.ready = !out_valid_q || led.ready;
	assign accept     = tick.valid && tick.ready;
	assign cfg.ready  = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FRAMES_RESET;
			period_q <= PERIOD_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_FRAMES_PER_SHIFT: frames_q <= cfg.data;
				CFG_PWM_PERIOD:       period_q <= cfg.data;
				default:              frames_q <= frames_q;
			endcase
		end
	end

	// counter advance and phase sequencing
	always_comb begin
		cur_phase  = (phase_q == PH_CENTER || phase_q == PH_LEFT) ? phase_q : PH_RIGHT;
		step_inc   = {1'b0, step_q} + 1'b1;
		frame_inc  = {1'b0, frame_q} + 1'b1;
		rot_inc    = {1'b0, rot_q} + 1'b1;
		rot_limit  = (cur_phase == PH_CENTER) ? CENTER_ROTATIONS : SWEEP_ROTATIONS;
		step_wrap  = (step_inc >= {1'b0, period_q});
		frame_wrap = (frame_inc >= {1'b0, frames_q});
		phase_end  = (rot_inc >= rot_limit);
		case (cur_phase)
			PH_RIGHT:  next_phase = PH_LEFT;
			PH_LEFT:   next_phase = PH_CENTER;
			default:   next_phase = PH_RIGHT;
		endcase

		ctl.step = step_q;
		ctl.cmd  = CMD_HOLD;
		if (accept) begin
			if (tick.restart) begin
				ctl.cmd = CMD_LOAD_RIGHT;
			end else if (step_wrap && frame_wrap) begin
				if (phase_end) begin
					case (next_phase)
						PH_LEFT:   ctl.cmd = CMD_LOAD_LEFT;
						PH_CENTER: ctl.cmd = CMD_LOAD_CENTER;
						default:   ctl.cmd = CMD_LOAD_RIGHT;
					endcase
				end else begin
					case (cur_phase)
						PH_LEFT:   ctl.cmd = CMD_ROT_LEFT;
						PH_CENTER: ctl.cmd = CMD_CENTER_STEP;
						default:   ctl.cmd = CMD_ROT_RIGHT;
					endcase
				end
			end
		end
	end

	// step, frame, rotation and phase counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			frame_q <= '0;
			rot_q   <= '0;
			phase_q <= PH_RIGHT;
		end else if (accept) begin
			if (tick.restart) begin
				step_q  <= '0;
				frame_q <= '0;
				rot_q   <= '0;
				phase_q <= PH_RIGHT;
			end else if (!step_wrap) begin
				step_q <= step_inc[DUTY_W-1:0];
			end else begin
				step_q <= '0;
				if (!frame_wrap) begin
					frame_q <= frame_inc[CFG_W-1:0];
				end else begin
					frame_q <= '0;
					if (phase_end) begin
						rot_q   <= '0;
						phase_q <= next_phase;
					end else begin
						rot_q   <= rot_inc[ROT_W-1:0];
						phase_q <= cur_phase;
					end
				end
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (led.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, taken from the state before the update
	always_ff @(posedge clk) begin
		if (accept) begin
			if (tick.restart) begin
				levels_q    <= '1;
				phase_out_q <= PH_RIGHT;
				start_q     <= 1'b0;
			end else begin
				levels_q    <= led_off;
				phase_out_q <= cur_phase;
				start_q     <= (step_q == '0);
			end
		end
	end

	assign led.valid        = out_valid_q;
	assign led.led_levels   = levels_q;
	assign led.phase        = phase_out_q;
	assign led.period_start = start_q;

endmodule

`default_nettype wire
